// ----- design/kcl_pkg.sv -----
package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 4;

  localparam logic [7:0] NO_KEY            = 8'hFF;
  localparam logic [3:0] TRIAL_LIMIT_RST   = 4'd2;
  localparam logic [6:0] LOCKOUT_TICKS_RST = 7'd15;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_SETTING  = 2'd0,
    PH_ENTERING = 2'd1,
    PH_OPEN     = 2'd2,
    PH_LOCKED   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DIGIT      = 3'd1,
    EV_STORED     = 3'd2,
    EV_CORRECT    = 3'd3,
    EV_WRONG      = 3'd4,
    EV_LOCK_BEGIN = 3'd5,
    EV_LOCK_END   = 3'd6
  } event_t;

  typedef enum logic [0:0] {
    REG_TRIAL_LIMIT   = 1'b0,
    REG_LOCKOUT_TICKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    phase_t     phase;
    event_t     ev;
    logic [2:0] digits;
    logic [3:0] trials;
    logic [6:0] seconds;
  } result_t;

  typedef struct packed {
    logic       is_open;
    logic [2:0] count;
    logic [3:0] trials;
    logic [6:0] lockout;
  } status_t;

endpackage

// ----- design/kcl_core.sv -----
module kcl_core #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             kind,
  input  logic [7:0]       key_code,
  input  logic [3:0]       trial_limit,
  input  logic [6:0]       lockout_ticks,
  output kcl_pkg::result_t result,
  output kcl_pkg::status_t status
);

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [2:0] LAST = 3'(CODE_DIGITS - 1);

  logic [7:0] stored_code [CODE_DIGITS];
  logic [7:0] stored_code_next [CODE_DIGITS];
  logic [7:0] entry_digits [CODE_DIGITS];
  logic [7:0] entry_digits_next [CODE_DIGITS];
  logic       code_is_set, code_is_set_next;
  logic [2:0] digit_count, digit_count_next;
  logic [3:0] trials_remaining, trials_remaining_next;
  logic [6:0] lockout_remaining, lockout_remaining_next;
  logic       is_open, is_open_next;
  kcl_pkg::event_t ev;

  always_comb begin
    logic       same;
    logic [3:0] dec;
    logic [7:0] digit;
    stored_code_next       = stored_code;
    entry_digits_next      = entry_digits;
    code_is_set_next       = code_is_set;
    digit_count_next       = digit_count;
    trials_remaining_next  = trials_remaining;
    lockout_remaining_next = lockout_remaining;
    is_open_next           = is_open;
    ev                     = kcl_pkg::EV_NONE;
    same                   = 1'b1;
    dec                    = trials_remaining;
    digit                  = 8'd0;

    // the last digit of an entry is compared straight from the key
    for (int i = 0; i < CODE_DIGITS; i++) begin
      digit = (i == CODE_DIGITS - 1) ? key_code : entry_digits[i];
      if (digit != stored_code[i]) same = 1'b0;
    end
    if (trials_remaining != 4'd0) dec = trials_remaining - 4'd1;

    if (!is_open) begin
      if (kind == kcl_pkg::KIND_TICK) begin
        if (lockout_remaining != 7'd0) begin
          lockout_remaining_next = lockout_remaining - 7'd1;
          if (lockout_remaining == 7'd1) begin
            trials_remaining_next = (trial_limit == 4'd0) ? 4'd1 : trial_limit;
            ev = kcl_pkg::EV_LOCK_END;
          end
        end
      end else if (key_code != kcl_pkg::NO_KEY && lockout_remaining == 7'd0) begin
        if (!code_is_set) begin
          stored_code_next[digit_count[IDX_W-1:0]] = key_code;
          if (digit_count == LAST) begin
            digit_count_next = 3'd0;
            code_is_set_next = 1'b1;
            ev = kcl_pkg::EV_STORED;
          end else begin
            digit_count_next = digit_count + 3'd1;
            ev = kcl_pkg::EV_DIGIT;
          end
        end else begin
          entry_digits_next[digit_count[IDX_W-1:0]] = key_code;
          if (digit_count != LAST) begin
            digit_count_next = digit_count + 3'd1;
            ev = kcl_pkg::EV_DIGIT;
          end else begin
            digit_count_next = 3'd0;
            if (same) begin
              is_open_next = 1'b1;
              ev = kcl_pkg::EV_CORRECT;
            end else begin
              trials_remaining_next = dec;
              if (dec == 4'd0) begin
                lockout_remaining_next = (lockout_ticks == 7'd0) ? 7'd1 : lockout_ticks;
                ev = kcl_pkg::EV_LOCK_BEGIN;
              end else begin
                ev = kcl_pkg::EV_WRONG;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (is_open_next) begin
      result.phase = kcl_pkg::PH_OPEN;
    end else if (!code_is_set_next) begin
      result.phase = kcl_pkg::PH_SETTING;
    end else if (lockout_remaining_next != 7'd0) begin
      result.phase = kcl_pkg::PH_LOCKED;
    end else begin
      result.phase = kcl_pkg::PH_ENTERING;
    end
    result.ev      = ev;
    result.digits  = digit_count_next;
    result.trials  = trials_remaining_next;
    result.seconds = lockout_remaining_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_is_set       <= 1'b0;
      digit_count       <= 3'd0;
      trials_remaining  <= kcl_pkg::TRIAL_LIMIT_RST;
      lockout_remaining <= 7'd0;
      is_open           <= 1'b0;
    end else if (step) begin
      code_is_set       <= code_is_set_next;
      digit_count       <= digit_count_next;
      trials_remaining  <= trials_remaining_next;
      lockout_remaining <= lockout_remaining_next;
      is_open           <= is_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      stored_code  <= stored_code_next;
      entry_digits <= entry_digits_next;
    end
  end

  assign status.is_open = is_open;
  assign status.count   = digit_count;
  assign status.trials  = trials_remaining;
  assign status.lockout = lockout_remaining;

endmodule

// ----- design/keypad_code_lock_with_lockout.sv -----
// keypad code lock with trial counting and timed lockout
// timing: an accepted item waits in the input register, and its result is registered in the output register
// once that register is free or being taken
// throughput: one item per cycle while the output is not stalled; the state update is a single compare-and-count step
// an input register and an output register sit around the core, so one further item is
// taken while a result waits; reset clears the lock state, sets trials to 2 and restores both registers
module keypad_code_lock_with_lockout #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] phase,
  output logic [2:0] event_res,
  output logic [2:0] digits_taken,
  output logic [3:0] trials_left,
  output logic [6:0] seconds_left
);

  logic [3:0] trial_limit;
  logic [6:0] lockout_ticks;
  logic       s1_valid;
  logic       s1_kind;
  logic [7:0] s1_key;
  logic       advance;
  logic       fire;
  kcl_pkg::result_t res;
  kcl_pkg::result_t out_res;
  kcl_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_limit   <= kcl_pkg::TRIAL_LIMIT_RST;
      lockout_ticks <= kcl_pkg::LOCKOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (kcl_pkg::cfg_reg_t'(cfg_index))
        kcl_pkg::REG_TRIAL_LIMIT:   trial_limit   <= cfg_data[3:0];
        kcl_pkg::REG_LOCKOUT_TICKS: lockout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_key  <= key_code;
    end
  end

  kcl_core #(
    .CODE_DIGITS(CODE_DIGITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .kind         (s1_kind),
    .key_code     (s1_key),
    .trial_limit  (trial_limit),
    .lockout_ticks(lockout_ticks),
    .result       (res),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign phase        = out_res.phase;
  assign event_res    = out_res.ev;
  assign digits_taken = out_res.digits;
  assign trials_left  = out_res.trials;
  assign seconds_left = out_res.seconds;

  // once open the lock stays open until reset
  assert property (@(posedge clk) disable iff (rst) status.is_open |=> status.is_open)
    else $error("lock closed again after opening");

  // a lockout only runs with the trials used up
  assert property (@(posedge clk) disable iff (rst)
    (status.lockout != 7'd0) |-> (status.trials == 4'd0))
    else $error("lockout running with trials left");

  assert property (@(posedge clk) disable iff (rst)
    {1'b0, status.count} < 4'(CODE_DIGITS))
    else $error("digit count beyond code length");

  assert property (@(posedge clk) disable iff (rst)
    status.is_open |-> (status.lockout == 7'd0))
    else $error("open while locked out");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS = kcl_pkg::CODE_DIGITS_DEF;

  typedef struct packed {
    logic [DIGITS-1:0][7:0] code;
    logic [DIGITS-1:0][7:0] entry;
    logic                   code_set;
    logic                   opened;
    logic [2:0]             count;
    logic [3:0]             trials;
    logic [6:0]             lockout;
    logic [3:0]             trial_lim;
    logic [6:0]             tick_lim;
  } lock_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] key;
  } press_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = kcl_pkg::REG_TRIAL_LIMIT;
  logic [6:0] cfg_data = 7'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = kcl_pkg::KIND_KEY;
  logic [7:0] key_code = kcl_pkg::NO_KEY;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] phase;
  logic [2:0] event_res;
  logic [2:0] digits_taken;
  logic [3:0] trials_left;
  logic [6:0] seconds_left;

  keypad_code_lock_with_lockout dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .key_code     (key_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .phase        (phase),
    .event_res    (event_res),
    .digits_taken (digits_taken),
    .trials_left  (trials_left),
    .seconds_left (seconds_left)
  );

  // lock_now follows accepted items, lock_ahead follows the queue as it is filled
  lock_state_t      lock_now;
  lock_state_t      lock_ahead;
  press_t           presses_pending[$];
  kcl_pkg::result_t status_due[$];
  int               presses_sent = 0;
  int               presses_taken = 0;
  int               faults = 0;
  bit               calm = 1'b0;
  bit               may_open = 1'b0;
  int               send_gap = 0;
  int               send_quiet = 0;
  int               hold_left = 0;
  int               hold_quiet = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic advance_lock(inout lock_state_t s, input logic k, input logic [7:0] key,
                              output kcl_pkg::result_t r);
    kcl_pkg::event_t ev;
    ev = kcl_pkg::EV_NONE;
    if (!s.opened) begin
      if (k == kcl_pkg::KIND_TICK) begin
        if (s.lockout != 7'd0) begin
          s.lockout = s.lockout - 7'd1;
          if (s.lockout == 7'd0) begin
            s.trials = (s.trial_lim == 4'd0) ? 4'd1 : s.trial_lim;
            ev = kcl_pkg::EV_LOCK_END;
          end
        end
      end else if (key != kcl_pkg::NO_KEY && s.lockout == 7'd0) begin
        if (!s.code_set) begin
          s.code[s.count] = key;
          s.count = s.count + 3'd1;
          if (s.count == 3'(DIGITS)) begin
            s.count = 3'd0;
            s.code_set = 1'b1;
            ev = kcl_pkg::EV_STORED;
          end else begin
            ev = kcl_pkg::EV_DIGIT;
          end
        end else begin
          s.entry[s.count] = key;
          s.count = s.count + 3'd1;
          if (s.count < 3'(DIGITS)) begin
            ev = kcl_pkg::EV_DIGIT;
          end else begin
            s.count = 3'd0;
            if (s.entry == s.code) begin
              s.opened = 1'b1;
              ev = kcl_pkg::EV_CORRECT;
            end else begin
              if (s.trials != 4'd0) s.trials = s.trials - 4'd1;
              if (s.trials == 4'd0) begin
                s.lockout = (s.tick_lim == 7'd0) ? 7'd1 : s.tick_lim;
                ev = kcl_pkg::EV_LOCK_BEGIN;
              end else begin
                ev = kcl_pkg::EV_WRONG;
              end
            end
          end
        end
      end
    end
    if (s.opened) r.phase = kcl_pkg::PH_OPEN;
    else if (!s.code_set) r.phase = kcl_pkg::PH_SETTING;
    else if (s.lockout != 7'd0) r.phase = kcl_pkg::PH_LOCKED;
    else r.phase = kcl_pkg::PH_ENTERING;
    r.ev      = ev;
    r.digits  = s.count;
    r.trials  = s.trials;
    r.seconds = s.lockout;
  endtask

  // an entry that would open the lock too early gets its last key nudged
  task automatic queue_press(input logic k, input logic [7:0] key);
    lock_state_t      trial;
    kcl_pkg::result_t r;
    trial = lock_ahead;
    advance_lock(trial, k, key, r);
    if (r.ev == kcl_pkg::EV_CORRECT && !may_open) key = (key == 8'd254) ? 8'd0 : key + 8'd1;
    advance_lock(lock_ahead, k, key, r);
    presses_pending.push_back('{kind: k, key: key});
  endtask

  task automatic queue_random(input int n);
    int          pick;
    logic [7:0]  key;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      key  = 8'($urandom_range(0, 254));
      if (lock_ahead.lockout != 7'd0) begin
        if (pick < 85) queue_press(kcl_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
        else queue_press(kcl_pkg::KIND_KEY, key);
      end else if (pick < 8) begin
        queue_press(kcl_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        queue_press(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
      end else if (pick < 55 && lock_ahead.count < 3'(DIGITS)) begin
        // right digit, so that most entries miss by little
        queue_press(kcl_pkg::KIND_KEY, lock_ahead.code[lock_ahead.count]);
      end else begin
        queue_press(kcl_pkg::KIND_KEY, key);
      end
    end
  endtask

  task automatic wait_lock_idle();
    while (presses_pending.size() != 0 || in_valid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(input logic [3:0] tl, input logic [6:0] lt);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = kcl_pkg::REG_TRIAL_LIMIT;
    cfg_data  = {3'($urandom_range(0, 7)), tl};
    @(negedge clk);
    cfg_index = kcl_pkg::REG_LOCKOUT_TICKS;
    cfg_data  = lt;
    @(negedge clk);
    cfg_we = 1'b0;
    lock_now.trial_lim   = tl;
    lock_now.tick_lim    = lt;
    lock_ahead.trial_lim = tl;
    lock_ahead.tick_lim  = lt;
  endtask

  task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
    faults++;
    if (faults <= 100)
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst || (in_valid && presses_taken != presses_sent)) begin
      // held until taken
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (presses_pending.size() != 0) begin
      press_t p;
      p = presses_pending.pop_front();
      kind     <= p.kind;
      key_code <= p.key;
      in_valid <= 1'b1;
      presses_sent++;
      if (send_quiet > 0) begin
        send_quiet--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap   = $urandom_range(1, 18);
        send_quiet = $urandom_range(0, 60);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_quiet > 0) begin
      hold_quiet--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      hold_left  = $urandom_range(1, 18) - 1;
      hold_quiet = $urandom_range(0, 60);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    kcl_pkg::result_t want;
    kcl_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        advance_lock(lock_now, kind, key_code, want);
        status_due.push_back(want);
        presses_taken++;
      end
      if (out_valid && !out_stall) begin
        got.phase   = kcl_pkg::phase_t'(phase);
        got.ev      = kcl_pkg::event_t'(event_res);
        got.digits  = digits_taken;
        got.trials  = trials_left;
        got.seconds = seconds_left;
        if (status_due.size() == 0) begin
          faults++;
          if (faults <= 100)
            $display("%0t ns: result with none expected, got phase %0d event %0d",
                     $time, phase, event_res);
        end else begin
          want = status_due.pop_front();
          if (got.phase !== want.phase)
            flag_field("phase", 8'(want.phase), 8'(got.phase));
          if (got.ev !== want.ev)
            flag_field("event_res", 8'(want.ev), 8'(got.ev));
          if (got.digits !== want.digits)
            flag_field("digits_taken", 8'(want.digits), 8'(got.digits));
          if (got.trials !== want.trials)
            flag_field("trials_left", 8'(want.trials), 8'(got.trials));
          if (got.seconds !== want.seconds)
            flag_field("seconds_left", 8'(want.seconds), 8'(got.seconds));
        end
      end
    end
  end

  initial begin
    lock_now           = '0;
    lock_now.trials    = kcl_pkg::TRIAL_LIMIT_RST;
    lock_now.trial_lim = kcl_pkg::TRIAL_LIMIT_RST;
    lock_now.tick_lim  = kcl_pkg::LOCKOUT_TICKS_RST;
    lock_ahead         = lock_now;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // before a code exists: tick and no-key are ignored
    queue_press(kcl_pkg::KIND_TICK, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
    // store the code, a no-key in the middle
    queue_press(kcl_pkg::KIND_KEY, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
    queue_press(kcl_pkg::KIND_KEY, 8'hFE);
    queue_press(kcl_pkg::KIND_KEY, 8'h5A);
    queue_press(kcl_pkg::KIND_KEY, 8'hA5);
    // one wrong entry, then a near miss that starts the lockout
    queue_press(kcl_pkg::KIND_KEY, 8'hFE);
    queue_press(kcl_pkg::KIND_KEY, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, 8'h5A);
    queue_press(kcl_pkg::KIND_KEY, 8'hA5);
    queue_press(kcl_pkg::KIND_KEY, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, 8'hFE);
    queue_press(kcl_pkg::KIND_KEY, 8'h5A);
    queue_press(kcl_pkg::KIND_KEY, 8'hA4);
    queue_press(kcl_pkg::KIND_KEY, 8'h00);
    queue_press(kcl_pkg::KIND_TICK, 8'hFF);
    repeat (14) queue_press(kcl_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    wait_lock_idle();

    set_limits(4'd1, 7'd1);
    queue_random(300);
    wait_lock_idle();
    set_limits(4'd15, 7'd99);
    queue_random(300);
    wait_lock_idle();
    // zero settings behave as one
    set_limits(4'd0, 7'd0);
    queue_random(300);
    wait_lock_idle();
    set_limits(4'($urandom_range(1, 15)), 7'($urandom_range(1, 99)));
    queue_random(300);
    wait_lock_idle();
    set_limits(4'($urandom_range(1, 15)), 7'($urandom_range(1, 99)));
    queue_random(300);
    wait_lock_idle();
    set_limits(kcl_pkg::TRIAL_LIMIT_RST, kcl_pkg::LOCKOUT_TICKS_RST);
    calm = 1'b1;
    queue_random(300);

    // finish any lockout or partial entry, then open the lock
    may_open = 1'b1;
    while (lock_ahead.lockout != 7'd0 || lock_ahead.count != 3'd0) begin
      if (lock_ahead.lockout != 7'd0)
        queue_press(kcl_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
      else queue_press(kcl_pkg::KIND_KEY, 8'($urandom_range(0, 254)));
    end
    for (int i = 0; i < DIGITS; i++) queue_press(kcl_pkg::KIND_KEY, lock_ahead.code[i]);
    // everything is ignored once open
    queue_press(kcl_pkg::KIND_TICK, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, 8'h00);
    queue_press(kcl_pkg::KIND_KEY, kcl_pkg::NO_KEY);
    queue_press(kcl_pkg::KIND_KEY, 8'hFE);

    wait_lock_idle();
    repeat (20) @(posedge clk);
    if (faults == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
